// ===== rtl/glos_pkg.sv =====
// ----------------------------------------------------------------------------
// glos_pkg
// Shared sizes, codes and types of the grid line-of-sight checker.
// ----------------------------------------------------------------------------
package glos_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int FRAC_BITS  = 16;

  localparam int IN_W    = 16;
  localparam int SIZE_W  = 7;
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CELL_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int POS_W   = CELL_W + FRAC_BITS;

  localparam int UP_SHIFT   = (FRAC_BITS >= IN_W) ? (FRAC_BITS - IN_W) : 0;
  localparam int DOWN_SHIFT = (FRAC_BITS < IN_W) ? (IN_W - FRAC_BITS) : 0;
  localparam int PROD_W     = IN_W + SIZE_W + UP_SHIFT;

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int COORD_W = CELL_W + 3;
  localparam int CNT_W   = CELL_W + 2;
  localparam int FR_W    = FRAC_BITS + 1;
  localparam int MUL_W   = FR_W + POS_W;
  localparam int ERR_W   = MUL_W + 3;

  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    FUNC_SET   = 2'd0,
    FUNC_LINE  = 2'd1,
    FUNC_POINT = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } grid_size_t;

  typedef struct packed {
    func_t            func;
    logic [POS_W-1:0] x0;
    logic [POS_W-1:0] y0;
    logic [POS_W-1:0] x1;
    logic [POS_W-1:0] y1;
    logic             walk_value;
  } item_t;

  // fraction s / 2^16 scaled by n, FRAC_BITS fraction bits
  function automatic logic [POS_W-1:0] to_units(input logic [IN_W-1:0] s,
                                                input logic [SIZE_W-1:0] n);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(n);
    return POS_W'((p << UP_SHIFT) >> DOWN_SHIFT);
  endfunction

endpackage

// ===== rtl/glos_front.sv =====
// ----------------------------------------------------------------------------
// glos_front
// Input stage: takes a transfer, scales the points to grid units and holds
// the classified item until the queue takes it.
// ----------------------------------------------------------------------------
module glos_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clearing,
  input  glos_pkg::grid_size_t     size,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               func,
  input  logic [glos_pkg::IN_W-1:0] start_x,
  input  logic [glos_pkg::IN_W-1:0] start_y,
  input  logic [glos_pkg::IN_W-1:0] end_x,
  input  logic [glos_pkg::IN_W-1:0] end_y,
  input  logic                     walk_value,
  output logic                     push,
  output glos_pkg::item_t          push_item,
  input  logic                     q_full
);
  import glos_pkg::*;

  logic  f_valid;
  item_t f_item;
  logic  accept;

  assign push      = f_valid && !q_full;
  assign in_stall  = clearing || (f_valid && q_full);
  assign accept    = in_valid && !in_stall;
  assign push_item = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item.func       <= func_t'(func);
      f_item.x0         <= to_units(start_x, size.w);
      f_item.y0         <= to_units(start_y, size.h);
      f_item.x1         <= to_units(end_x, size.w);
      f_item.y1         <= to_units(end_y, size.h);
      f_item.walk_value <= walk_value;
    end
  end

endmodule

// ===== rtl/glos_queue.sv =====
// ----------------------------------------------------------------------------
// glos_queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module glos_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  glos_pkg::item_t push_item,
  output logic            full,
  output logic            q_valid,
  output glos_pkg::item_t q_item,
  input  logic            pop
);
  import glos_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_QW = $clog2(Q_DEPTH + 1);

  item_t             slots [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_QW'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/glos_back.sv =====
// ----------------------------------------------------------------------------
// glos_back
// Execution end: owns the walkability bitmap, runs sets, point reads and the
// cell-by-cell line walk, and holds the result register.
// ----------------------------------------------------------------------------
module glos_back (
  input  logic                 clk,
  input  logic                 rst,
  input  glos_pkg::grid_size_t size,
  input  logic                 q_valid,
  input  glos_pkg::item_t      q_item,
  output logic                 q_pop,
  output logic                 clearing,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 path_free,
  output logic                 cell_walkable
);
  import glos_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POINT,
    S_PREP,
    S_MUL1,
    S_MUL2,
    S_WALK,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] d;
    logic [FR_W-1:0]  frac;
    logic [CNT_W-1:0] cells;
    logic             neg;
  } axis_t;

  function automatic axis_t axis_setup(input logic [POS_W-1:0] p0,
                                       input logic [POS_W-1:0] p1);
    axis_t             a;
    logic [CELL_W-1:0] c0;
    logic [CELL_W-1:0] c1;
    c0 = p0[POS_W-1:FRAC_BITS];
    c1 = p1[POS_W-1:FRAC_BITS];
    if (p1 > p0) begin
      a.d     = p1 - p0;
      a.neg   = 1'b0;
      a.frac  = (FR_W'(1) << FRAC_BITS) - FR_W'(p0[FRAC_BITS-1:0]);
      a.cells = CNT_W'(c1) - CNT_W'(c0);
    end else begin
      a.d     = p0 - p1;
      a.neg   = 1'b1;
      a.frac  = FR_W'(p0[FRAC_BITS-1:0]);
      a.cells = CNT_W'(c0) - CNT_W'(c1);
    end
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CELL_W-1:0] cx,
                                                  input logic [CELL_W-1:0] cy);
    return ADDR_W'(cy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx);
  endfunction

  logic mem [MEM_DEPTH];

  state_t              state;
  logic [ADDR_W-1:0]   clr_addr;
  item_t               item;
  logic                rd_data;
  logic                pend_oob;
  logic                pend_valid;
  logic                free_acc;
  logic                res_path;
  logic                res_cell;
  logic [POS_W-1:0]    dx;
  logic [POS_W-1:0]    dy;
  logic [FR_W-1:0]     fx;
  logic [FR_W-1:0]     fy;
  logic                x_neg;
  logic                y_neg;
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic [CNT_W-1:0]    n_left;
  logic [MUL_W-1:0]    prod;
  logic signed [ERR_W-1:0] err;

  logic              grid_on;
  logic              inb;
  logic              step_y;
  logic              pend_ok;
  logic              acc_next;
  logic              load_out;
  axis_t             ax;
  axis_t             ay;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign grid_on  = (size.w != '0) && (size.h != '0);
  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign load_out = (state == S_RESULT) && (!out_valid || !out_stall);
  assign pend_ok  = !pend_oob && rd_data;
  assign acc_next = free_acc && (!pend_valid || pend_ok);
  assign ax       = axis_setup(item.x0, item.x1);
  assign ay       = axis_setup(item.y0, item.y1);

  assign inb = !x[COORD_W-1] && !y[COORD_W-1] &&
               (x < $signed(COORD_W'(size.w))) && (y < $signed(COORD_W'(size.h)));

  always_comb begin
    if (dx == '0) begin
      step_y = 1'b1;
    end else if (dy == '0) begin
      step_y = 1'b0;
    end else begin
      step_y = (err > 0);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = 1'b1;
    rd_en   = 1'b0;
    rd_addr = cell_addr(q_item.x0[POS_W-1:FRAC_BITS], q_item.y0[POS_W-1:FRAC_BITS]);
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        wr_addr = rd_addr;
        wr_data = q_item.walk_value;
        wr_en   = q_valid && (q_item.func == FUNC_SET) && grid_on;
        rd_en   = q_valid && (q_item.func == FUNC_POINT);
      end
      S_WALK: begin
        rd_addr = cell_addr(x[CELL_W-1:0], y[CELL_W-1:0]);
        rd_en   = (n_left != '0) && inb;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid     <= 1'b1;
        path_free     <= res_path;
        cell_walkable <= res_cell;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            item     <= q_item;
            res_path <= 1'b0;
            res_cell <= 1'b0;
            unique case (q_item.func)
              FUNC_SET:   state <= S_RESULT;
              FUNC_LINE:  state <= S_PREP;
              FUNC_POINT: begin
                pend_oob <= !grid_on;
                state    <= S_POINT;
              end
              FUNC_NOP:   state <= S_RESULT;
            endcase
          end
        end
        S_POINT: begin
          res_cell <= pend_ok;
          state    <= S_RESULT;
        end
        S_PREP: begin
          dx     <= ax.d;
          dy     <= ay.d;
          fx     <= ax.frac;
          fy     <= ay.frac;
          x_neg  <= ax.neg;
          y_neg  <= ay.neg;
          n_left <= CNT_W'(1) + ax.cells + ay.cells;
          x      <= $signed(COORD_W'(item.x0[POS_W-1:FRAC_BITS]));
          y      <= $signed(COORD_W'(item.y0[POS_W-1:FRAC_BITS]));
          state  <= S_MUL1;
        end
        S_MUL1: begin
          prod  <= MUL_W'(fx) * MUL_W'(dy);
          state <= S_MUL2;
        end
        S_MUL2: begin
          err        <= $signed(ERR_W'(prod)) - $signed(ERR_W'(MUL_W'(fy) * MUL_W'(dx)));
          free_acc   <= 1'b1;
          pend_valid <= 1'b0;
          state      <= S_WALK;
        end
        S_WALK: begin
          if (n_left == '0) begin
            res_path   <= acc_next;
            pend_valid <= 1'b0;
            state      <= S_RESULT;
          end else begin
            free_acc   <= acc_next;
            pend_valid <= 1'b1;
            pend_oob   <= !inb;
            n_left     <= n_left - 1'b1;
            if (step_y) begin
              y   <= y_neg ? y - COORD_W'(1) : y + COORD_W'(1);
              err <= err - $signed(ERR_W'({dx, {FRAC_BITS{1'b0}}}));
            end else begin
              x   <= x_neg ? x - COORD_W'(1) : x + COORD_W'(1);
              err <= err + $signed(ERR_W'({dy, {FRAC_BITS{1'b0}}}));
            end
          end
        end
        S_RESULT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/grid_line_of_sight_check.sv =====
// ----------------------------------------------------------------------------
// grid_line_of_sight_check
// Walkability bitmap with cell set, point query and line-of-sight query.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   func start_x start_y end_x end_y walk_value
//   out      out_valid / out_stall path_free cell_walkable
//   cfg      cfg_write             cfg_index cfg_data
//
// One result per item. Set and unused func 3 pass S_IDLE and S_RESULT; a point
// query adds S_POINT; a line query adds S_PREP, S_MUL1, S_MUL2 and S_WALK, with
// one bitmap read per visited cell, n = 1 + |cell x change| + |cell y change|
// (up to 127). After reset a pass over the whole bitmap sets every cell walkable;
// in_stall is high during it. The input side keeps taking items while results
// wait on out_stall, until the front register and the queue are full.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [glos_pkg::SIZE_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 func,
  input  logic [glos_pkg::IN_W-1:0]  start_x,
  input  logic [glos_pkg::IN_W-1:0]  start_y,
  input  logic [glos_pkg::IN_W-1:0]  end_x,
  input  logic [glos_pkg::IN_W-1:0]  end_y,
  input  logic                       walk_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       path_free,
  output logic                       cell_walkable
);
  import glos_pkg::*;

  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  grid_size_t        size;
  logic              clearing;
  logic              push;
  item_t             push_item;
  logic              q_full;
  logic              q_valid;
  item_t             q_item;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_W'(64);
      grid_height <= SIZE_W'(64);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
      endcase
    end
  end

  assign size.w = (int'(grid_width) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : grid_width;
  assign size.h = (int'(grid_height) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : grid_height;

  glos_front u_front (
    .clk        (clk),
    .rst        (rst),
    .clearing   (clearing),
    .size       (size),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .walk_value (walk_value),
    .push       (push),
    .push_item  (push_item),
    .q_full     (q_full)
  );

  glos_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (q_pop)
  );

  glos_back u_back (
    .clk           (clk),
    .rst           (rst),
    .size          (size),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .path_free     (path_free),
    .cell_walkable (cell_walkable)
  );

endmodule

// ===== rtl/glos_checker.sv =====
// ----------------------------------------------------------------------------
// glos_checker
// Port-level checks of the grid line-of-sight checker, bound to the top.
// ----------------------------------------------------------------------------
module glos_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic path_free,
  input logic cell_walkable
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(path_free) && $stable(cell_walkable))
    else $error("stalled result changed");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(path_free && cell_walkable))
    else $error("both result flags set");

  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("input taken during bitmap clear");

endmodule

bind grid_line_of_sight_check glos_checker u_glos_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_line_of_sight_check. A scoreboard object keeps
// its own walkability map and grid size, predicts the flags of every accepted
// item, and compares each result transfer in order. Directed corner items come
// first, then random phases over many grid sizes with bursty input, a random
// output stall pattern and one long output hold-off.
// ----------------------------------------------------------------------------

typedef struct {
  glos_pkg::func_t op;
  logic [15:0]     sx;
  logic [15:0]     sy;
  logic [15:0]     ex;
  logic [15:0]     ey;
  logic            walk;
} grid_req_t;

class los_scoreboard;
  bit                         walkable [glos_pkg::MEM_DEPTH];
  logic [glos_pkg::SIZE_W-1:0] cols_reg;
  logic [glos_pkg::SIZE_W-1:0] rows_reg;
  bit [1:0]                   want_q [$];  // {path_free, cell_walkable}
  int                         mismatches;

  function new();
    foreach (walkable[i]) walkable[i] = 1'b1;
    cols_reg   = 7'd64;
    rows_reg   = 7'd64;
    mismatches = 0;
  endfunction

  function void write_reg(glos_pkg::reg_index_t idx, logic [glos_pkg::SIZE_W-1:0] val);
    if (idx == glos_pkg::REG_GRID_WIDTH) cols_reg = val;
    else rows_reg = val;
  endfunction

  function int pending();
    return want_q.size();
  endfunction

  function longint clip(logic [glos_pkg::SIZE_W-1:0] raw, int lim);
    return (raw > lim) ? lim : longint'(raw);
  endfunction

  // fraction s / 2^16 times n, FRAC_BITS fraction bits
  function longint scaled(logic [15:0] s, longint n);
    longint p;
    p = longint'(s) * n;
    if (glos_pkg::FRAC_BITS >= 16) p = p << (glos_pkg::FRAC_BITS - 16);
    else p = p >> (16 - glos_pkg::FRAC_BITS);
    return p;
  endfunction

  function bit open_cell(longint x, longint y, longint w, longint h);
    if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
    return walkable[y * glos_pkg::MAX_WIDTH + x];
  endfunction

  function void axis(input longint p0, input longint p1, output longint d,
                     output longint step, output longint frac, output longint cells);
    longint c0;
    longint c1;
    c0 = p0 >> glos_pkg::FRAC_BITS;
    c1 = p1 >> glos_pkg::FRAC_BITS;
    if (p1 > p0) begin
      d     = p1 - p0;
      step  = 1;
      frac  = ((c0 + 1) << glos_pkg::FRAC_BITS) - p0;
      cells = c1 - c0;
    end else begin
      d     = p0 - p1;
      step  = (p1 < p0) ? -1 : 0;
      frac  = p0 - (c0 << glos_pkg::FRAC_BITS);
      cells = c0 - c1;
    end
  endfunction

  function bit line_clear(grid_req_t r, longint w, longint h);
    longint x0, y0, x1, y1, dx, dy, xi, yi, fx, fy, nx, ny, x, y, err, n;
    bit     step_y;
    x0 = scaled(r.sx, w);
    y0 = scaled(r.sy, h);
    x1 = scaled(r.ex, w);
    y1 = scaled(r.ey, h);
    axis(x0, x1, dx, xi, fx, nx);
    axis(y0, y1, dy, yi, fy, ny);
    x   = x0 >> glos_pkg::FRAC_BITS;
    y   = y0 >> glos_pkg::FRAC_BITS;
    err = fx * dy - fy * dx;
    for (n = 1 + nx + ny; n > 0; n--) begin
      if (!open_cell(x, y, w, h)) return 1'b0;
      if (dx == 0) step_y = 1'b1;        // vertical: infinite error
      else if (dy == 0) step_y = 1'b0;
      else step_y = (err > 0);
      if (step_y) begin
        y   += yi;
        err -= dx << glos_pkg::FRAC_BITS;
      end else begin
        x   += xi;
        err += dy << glos_pkg::FRAC_BITS;
      end
    end
    return 1'b1;
  endfunction

  function void note_input(grid_req_t r);
    longint   w, h, cx, cy;
    bit [1:0] want;
    w    = clip(cols_reg, glos_pkg::MAX_WIDTH);
    h    = clip(rows_reg, glos_pkg::MAX_HEIGHT);
    cx   = (longint'(r.sx) * w) >> 16;
    cy   = (longint'(r.sy) * h) >> 16;
    want = 2'b00;
    case (r.op)
      glos_pkg::FUNC_SET: begin
        if (w != 0 && h != 0) walkable[cy * glos_pkg::MAX_WIDTH + cx] = r.walk;
      end
      glos_pkg::FUNC_LINE: want[1] = line_clear(r, w, h);
      glos_pkg::FUNC_POINT: want[0] = open_cell(cx, cy, w, h);
      default: ;
    endcase
    want_q = {want_q, want};
  endfunction

  function void check_result(logic pf, logic cw);
    bit [1:0] want;
    if (want_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result transfer: path_free=%b cell_walkable=%b", pf, cw);
      return;
    end
    want = want_q.pop_front();
    if (pf !== want[1] || cw !== want[0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: path_free exp %b got %b, cell_walkable exp %b got %b",
                 want[1], pf, want[0], cw);
    end
  endfunction
endclass

module tb;
  import glos_pkg::*;

  localparam int LIMIT       = 1_500_000;
  localparam int ITEMS       = 1900;
  localparam int PHASES      = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int FLOOD_ITEMS = 40;
  localparam logic [15:0] TOP = 16'hFFFF;
  localparam logic [15:0] MID = 16'h8000;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic              cfg_index;
  logic [SIZE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        func;
  logic [IN_W-1:0]   start_x;
  logic [IN_W-1:0]   start_y;
  logic [IN_W-1:0]   end_x;
  logic [IN_W-1:0]   end_y;
  logic              walk_value;
  logic              out_valid;
  logic              out_stall;
  logic              path_free;
  logic              cell_walkable;

  los_scoreboard sb;
  int            hold_requests = 0;
  int            burst_left = 0;

  grid_line_of_sight_check u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .walk_value    (walk_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .path_free     (path_free),
    .cell_walkable (cell_walkable)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic grid_req_t mk_req(func_t op, logic [15:0] sx, logic [15:0] sy,
                                       logic [15:0] ex, logic [15:0] ey, logic walk);
    grid_req_t r;
    r.op   = op;
    r.sx   = sx;
    r.sy   = sy;
    r.ex   = ex;
    r.ey   = ey;
    r.walk = walk;
    return r;
  endfunction

  function automatic logic [15:0] coord();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return TOP;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] near(logic [15:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 8191)) - 4096;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic grid_req_t random_req(int block_pct);
    grid_req_t r;
    int        pick;
    pick   = $urandom_range(0, 99);
    r.op   = (pick < 35) ? FUNC_SET : (pick < 75) ? FUNC_LINE :
             (pick < 95) ? FUNC_POINT : FUNC_NOP;
    r.sx   = coord();
    r.sy   = coord();
    r.walk = ($urandom_range(0, 99) < block_pct) ? 1'b0 : 1'b1;
    if (r.op == FUNC_LINE && $urandom_range(0, 1) == 1) begin
      r.ex = near(r.sx);
      r.ey = near(r.sy);
    end else begin
      r.ex = coord();
      r.ey = coord();
    end
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send(input grid_req_t r);
    in_valid   <= 1'b1;
    func       <= r.op;
    start_x    <= r.sx;
    start_y    <= r.sy;
    end_x      <= r.ex;
    end_y      <= r.ey;
    walk_value <= r.walk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(r);
    @(negedge clk);
  endtask

  task automatic pace(input int max_gap);
    if (max_gap == 0) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 15);
    in_valid <= 1'b0;
    repeat ($urandom_range(1, max_gap)) @(negedge clk);
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic set_grid(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    cfg_write <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    sb.write_reg(REG_GRID_WIDTH, w);
    @(negedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    sb.write_reg(REG_GRID_HEIGHT, h);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(path_free, cell_walkable);
  end

  initial begin : receiver
    int mode;
    int seg;
    int served;
    mode      = 0;
    seg       = 0;
    served    = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served = hold_requests;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (seg == 0) begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(20, 200);
      end
      seg--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 4) < 3);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin : watchdog
    int n;
    for (n = 0; n < LIMIT; n++) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int                p;
    int                k;
    int                per_phase;
    int                max_gap;
    int                block_pct;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    sb         = new();
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    func       = FUNC_SET;
    start_x    = '0;
    start_y    = '0;
    end_x      = '0;
    end_y      = '0;
    walk_value = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed items at the reset size
    send(mk_req(FUNC_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send(mk_req(FUNC_SET,   16'h0000, 16'h0000, TOP, TOP, 1'b0));
    send(mk_req(FUNC_POINT, 16'h0000, 16'h0000, TOP, TOP, 1'b1));
    send(mk_req(FUNC_SET,   TOP, TOP, 16'h0000, 16'h0000, 1'b0));
    send(mk_req(FUNC_POINT, TOP, TOP, TOP, TOP, 1'b0));
    send(mk_req(FUNC_LINE,  16'h0000, 16'h0000, TOP, TOP, 1'b0));
    send(mk_req(FUNC_SET,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send(mk_req(FUNC_LINE,  16'h0000, 16'h0000, TOP, TOP, 1'b0));
    send(mk_req(FUNC_SET,   TOP, TOP, TOP, TOP, 1'b1));
    send(mk_req(FUNC_LINE,  16'h0000, 16'h0000, TOP, TOP, 1'b1));
    send(mk_req(FUNC_LINE,  TOP, 16'h0000, 16'h0000, TOP, 1'b0));
    send(mk_req(FUNC_SET,   MID, MID, 16'h0000, 16'h0000, 1'b0));
    send(mk_req(FUNC_LINE,  MID, 16'h0000, MID, TOP, 1'b0));         // zero dx
    send(mk_req(FUNC_LINE,  16'h0000, MID, TOP, MID, 1'b0));         // zero dy
    send(mk_req(FUNC_LINE,  MID, MID, MID, MID, 1'b0));              // single cell
    send(mk_req(FUNC_LINE,  16'h1000, 16'h1000, 16'h1000, 16'h1000, 1'b0));
    send(mk_req(FUNC_LINE,  TOP, TOP, 16'h0000, 16'h0000, 1'b0));
    send(mk_req(FUNC_LINE,  16'h0000, TOP, TOP, TOP, 1'b0));
    send(mk_req(FUNC_NOP,   TOP, TOP, TOP, TOP, 1'b1));
    send(mk_req(FUNC_POINT, MID, MID, 16'h0000, 16'h0000, 1'b1));
    send(mk_req(FUNC_SET,   MID, MID, TOP, TOP, 1'b1));
    send(mk_req(FUNC_LINE,  MID, 16'h0000, MID, TOP, 1'b1));
    send(mk_req(FUNC_LINE,  16'h0000, MID, TOP, MID, 1'b1));
    drain(8);

    per_phase = ITEMS / PHASES;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin w = 7'd64;  h = 7'd64;  end
        1: begin w = 7'd1;   h = 7'd1;   end
        2: begin w = 7'd127; h = 7'd127; end
        3: begin w = 7'd0;   h = 7'd9;   end
        4: begin w = 7'd9;   h = 7'd0;   end
        5: begin w = 7'd64;  h = 7'd1;   end
        6: begin w = 7'd1;   h = 7'd64;  end
        7: begin w = 7'd65;  h = 7'd100; end
        default: begin
          w = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(1, 16));
          h = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(1, 16));
        end
      endcase
      set_grid(w, h);
      max_gap = (p % 3 == 0) ? 0 : $urandom_range(2, 20);
      case ($urandom_range(0, 2))
        0: block_pct = 20;
        1: block_pct = 50;
        default: block_pct = 85;
      endcase
      for (k = 0; k < per_phase; k++) begin
        if (p == 0 && k == 0) hold_requests <= hold_requests + 1;
        if (p == 5 && k == per_phase / 2) drain(0);
        send(random_req(block_pct));
        if (!(p == 0 && k < FLOOD_ITEMS)) pace(max_gap);
      end
      drain(8);
    end

    drain(150);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/glos_pkg.sv
rtl/glos_front.sv
rtl/glos_queue.sv
rtl/glos_back.sv
rtl/grid_line_of_sight_check.sv
rtl/glos_checker.sv
test/tb.sv
